/* design/rau_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the rational arithmetic unit
// no dependencies
package rau_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned FIELD_WIDTH = 32;
  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned MW = PW;
  localparam int unsigned CW = $clog2(MW);
  localparam logic [MW-1:0] DEN_LIM = {{(MW-1){1'b0}}, 1'b1} << (W - 1);

  typedef enum logic [2:0] {
    ACT_NORM = 3'd0,
    ACT_ADD  = 3'd1,
    ACT_SUB  = 3'd2,
    ACT_MUL  = 3'd3,
    ACT_DIV  = 3'd4,
    ACT_LESS = 3'd5,
    ACT_EQ   = 3'd6,
    ACT_NE   = 3'd7
  } act_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_BAD_DEN  = 2'd3
  } status_t;

  typedef struct packed {
    act_t                          action;
    logic signed [FIELD_WIDTH-1:0] lhs_num;
    logic signed [FIELD_WIDTH-1:0] lhs_den;
    logic signed [FIELD_WIDTH-1:0] rhs_num;
    logic signed [FIELD_WIDTH-1:0] rhs_den;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] res_num;
    logic [FIELD_WIDTH-2:0]        res_den;
    logic                          truth;
    status_t                       status;
  } out_item_t;

  // classified request: three multiplier operand pairs
  typedef struct packed {
    act_t              act;
    logic              bad;
    logic              sub;
    logic signed [W-1:0] x0;
    logic signed [W-1:0] y0;
    logic signed [W-1:0] x1;
    logic signed [W-1:0] y1;
    logic signed [W-1:0] x2;
    logic signed [W-1:0] y2;
  } op_entry_t;

  typedef struct packed {
    logic      valid;
    op_entry_t data;
  } q_out_t;

endpackage

/* design/rau_front.sv */
`timescale 1ns / 1ps
// front end: accepts requests, checks denominators, picks multiplier operands
// depends on rau_pkg
module rau_front import rau_pkg::*; (
  input  logic      in_valid,
  input  in_item_t  in_data,
  output logic      in_stall,
  input  logic      q_full,
  output logic      push,
  output op_entry_t entry
);

  logic signed [W-1:0] a, b, c, d;
  logic signed [W-1:0] one_v, zero_v;
  logic bad_b, bad_d;

  assign a = in_data.lhs_num[W-1:0];
  assign b = in_data.lhs_den[W-1:0];
  assign c = in_data.rhs_num[W-1:0];
  assign d = in_data.rhs_den[W-1:0];
  assign one_v  = {{(W-1){1'b0}}, 1'b1};
  assign zero_v = '0;
  assign bad_b  = b[W-1] || (b == zero_v);
  assign bad_d  = d[W-1] || (d == zero_v);

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    entry.act = in_data.action;
    entry.bad = (in_data.action != ACT_NORM) && (bad_b || bad_d);
    entry.sub = (in_data.action == ACT_SUB);
    entry.x0 = a;
    entry.y0 = d;
    entry.x1 = c;
    entry.y1 = b;
    entry.x2 = b;
    entry.y2 = d;
    unique case (in_data.action) inside
      ACT_NORM: begin
        entry.y0 = one_v;
        entry.x1 = zero_v;
        entry.y1 = zero_v;
        entry.y2 = one_v;
      end
      ACT_MUL: begin
        entry.y0 = c;
        entry.x1 = zero_v;
        entry.y1 = zero_v;
      end
      ACT_DIV: begin
        entry.x1 = zero_v;
        entry.y1 = zero_v;
        entry.y2 = c;
      end
      ACT_ADD, ACT_SUB, ACT_LESS, ACT_EQ, ACT_NE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/rau_queue.sv */
`timescale 1ns / 1ps
// two-entry queue between front and back end
// depends on rau_pkg
module rau_queue import rau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  op_entry_t push_data,
  output logic      full,
  input  logic      pop,
  output q_out_t    head
);

  op_entry_t  mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full       = (count_r == 2'd2);
  assign head.valid = (count_r != 2'd0);
  assign head.data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop) count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

endmodule

/* design/rau_back.sv */
`timescale 1ns / 1ps
// back end: products on one multiplier, binary gcd, restoring divide, result register
// depends on rau_pkg
module rau_back import rau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_out_t    head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_COMB, S_GCD, S_DIV, S_FIN} state_t;

  state_t              state_r;
  op_entry_t           ent_r;
  logic [CW-1:0]       cnt_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r;
  logic [MW-1:0]       x_r, y_r, g_r, qn_r, qd_r, rn_r, rd_r;
  logic                neg_r, truth_r;
  status_t             st_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  // multiplier
  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] prod;

  always_comb begin
    case (cnt_r)
      CW'(0): begin
        mul_a = ent_r.x0;
        mul_b = ent_r.y0;
      end
      CW'(1): begin
        mul_a = ent_r.x1;
        mul_b = ent_r.y1;
      end
      default: begin
        mul_a = ent_r.x2;
        mul_b = ent_r.y2;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // combine products into numerator and denominator magnitudes
  logic signed [SW-1:0] sum_c;
  logic [SW-1:0]        nabs, dabs;
  logic [MW-1:0]        mn_c, md_c;
  logic                 neg_c;
  logic                 cmp_c;

  assign sum_c = ent_r.sub ? (SW'(p0_r) - SW'(p1_r)) : (SW'(p0_r) + SW'(p1_r));
  assign nabs  = sum_c[SW-1] ? SW'(-sum_c) : SW'(sum_c);
  assign dabs  = p2_r[PW-1] ? SW'(-SW'(p2_r)) : SW'(p2_r);
  assign mn_c  = nabs[MW-1:0];
  assign md_c  = dabs[MW-1:0];
  assign neg_c = (sum_c[SW-1] != p2_r[PW-1]) && (mn_c != '0);

  // cross product compare
  always_comb begin
    unique case (ent_r.act) inside
      ACT_LESS: cmp_c = (p0_r < p1_r);
      ACT_EQ:   cmp_c = (p0_r == p1_r);
      default:  cmp_c = (p0_r != p1_r);
    endcase
  end

  // one restoring divide step for both values
  logic [MW:0] gx, tn, td, tn_sub, td_sub;
  logic        bn, bd;
  assign gx     = {1'b0, g_r};
  assign tn     = {rn_r, qn_r[MW-1]};
  assign td     = {rd_r, qd_r[MW-1]};
  assign tn_sub = tn - gx;
  assign td_sub = td - gx;
  assign bn     = (tn >= gx);
  assign bd     = (td >= gx);

  // final range check and packing
  logic          is_arith, ovf, out_free;
  status_t       fin_st;
  logic [W-1:0]  num_v;
  out_item_t     fin_data;

  assign is_arith = (ent_r.act < ACT_LESS);
  assign ovf      = (qd_r >= DEN_LIM) || (neg_r ? (qn_r > DEN_LIM) : (qn_r >= DEN_LIM));
  assign fin_st   = (st_r == ST_OK && is_arith && ovf) ? ST_OVERFLOW : st_r;
  assign num_v    = neg_r ? (-qn_r[W-1:0]) : qn_r[W-1:0];
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    fin_data.status  = fin_st;
    fin_data.truth   = truth_r && (fin_st == ST_OK) && !is_arith;
    fin_data.res_num = '0;
    fin_data.res_den = '0;
    if (fin_st == ST_OK && is_arith) begin
      fin_data.res_num = FIELD_WIDTH'($signed(num_v));
      fin_data.res_den = (FIELD_WIDTH-1)'(qd_r[W-2:0]);
    end
  end

  assign pop       = (state_r == S_IDLE) && head.valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_FIN)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (head.valid) begin
            ent_r   <= head.data;
            cnt_r   <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          case (cnt_r)
            CW'(0):  p0_r <= prod;
            CW'(1):  p1_r <= prod;
            default: p2_r <= prod;
          endcase
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(2)) state_r <= S_COMB;
        end
        S_COMB: begin
          truth_r <= cmp_c;
          neg_r   <= neg_c;
          qn_r    <= mn_c;
          // zero value becomes 0/1
          qd_r    <= (mn_c == '0) ? {{(MW-1){1'b0}}, 1'b1} : md_c;
          x_r     <= mn_c;
          y_r     <= md_c;
          if (ent_r.bad) begin
            st_r    <= ST_BAD_DEN;
            state_r <= S_FIN;
          end else if (!is_arith) begin
            st_r    <= ST_OK;
            state_r <= S_FIN;
          end else if (md_c == '0) begin
            st_r    <= ST_ZERO_DEN;
            state_r <= S_FIN;
          end else if (mn_c == '0) begin
            st_r    <= ST_OK;
            state_r <= S_FIN;
          end else begin
            st_r    <= ST_OK;
            state_r <= S_GCD;
          end
        end
        S_GCD: begin
          if (x_r == y_r) begin
            g_r     <= x_r;
            rn_r    <= '0;
            rd_r    <= '0;
            cnt_r   <= '0;
            state_r <= S_DIV;
          end else if (!x_r[0] && !y_r[0]) begin
            // common factor of two comes straight off both values
            x_r  <= x_r >> 1;
            y_r  <= y_r >> 1;
            qn_r <= qn_r >> 1;
            qd_r <= qd_r >> 1;
          end else if (!x_r[0]) begin
            x_r <= x_r >> 1;
          end else if (!y_r[0]) begin
            y_r <= y_r >> 1;
          end else if (x_r > y_r) begin
            x_r <= x_r - y_r;
          end else begin
            y_r <= y_r - x_r;
          end
        end
        S_DIV: begin
          rn_r  <= bn ? tn_sub[MW-1:0] : tn[MW-1:0];
          rd_r  <= bd ? td_sub[MW-1:0] : td[MW-1:0];
          qn_r  <= {qn_r[MW-2:0], bn};
          qd_r  <= {qd_r[MW-2:0], bd};
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(MW - 1)) state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_data_r  <= fin_data;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/rational_arith_unit.sv */
`timescale 1ns / 1ps
// rational arithmetic unit: normalize, add, sub, mul, div and compare of fractions
// comparisons, zero results and error cases skip reduction; reductions run the binary gcd
// (one step per cycle) and then a restoring divide of both 64-bit magnitudes by the gcd;
// one request is reduced at a time, a two-entry queue takes new requests
// meanwhile. synchronous active-low reset empties the queue and the result register
// depends on rau_pkg, rau_front, rau_queue, rau_back
module rational_arith_unit import rau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_item_t  in_data,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      q_full, push, pop;
  op_entry_t entry;
  q_out_t    head;

  rau_front u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .push     (push),
    .entry    (entry)
  );

  rau_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (entry),
    .full      (q_full),
    .pop       (pop),
    .head      (head)
  );

  rau_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
